// ===== hw/rtl/bascnd_pkg.sv =====
// ---------------------------------------------------------------------------
// bascnd_pkg
// Shared widths, constants and types of the bridge ADC sample conditioner.
// ---------------------------------------------------------------------------
`default_nettype none

package bascnd_pkg;

    localparam int RAW_W     = 24;
    localparam int LEVEL_W   = 11;
    localparam int GAIN_W    = 16;
    localparam int TLOW_W    = 13;
    localparam int HELD_W    = 23;
    localparam int DIVD_W    = 37;
    localparam int STEP_W    = 6;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [RAW_W-1:0]   ZERO_MID     = 24'h800000;
    localparam int                 SAMPLE_SHIFT = 10;
    localparam logic [9:0]         DIR_SCALE    = 10'd1000;
    localparam logic [13:0]        RANGE_SCALE  = 14'd10000;
    localparam logic [GAIN_W-1:0]  DIR_DEFAULT  = 16'd1000;
    localparam logic [GAIN_W-1:0]  RANGE_DEFAULT = 16'd10000;
    localparam logic [DIVD_W-1:0]  CLAMP_LIMIT  = 37'd1368;
    localparam logic [LEVEL_W-1:0] CLAMP_VALUE  = 11'd1268;
    localparam logic [HELD_W-1:0]  HELD_MAX     = 23'd8191000;

    localparam logic [STEP_W-1:0]  STEPS_DIR    = 6'd23;
    localparam logic [STEP_W-1:0]  STEPS_RANGE  = 6'd37;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR_GAIN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GAIN = 1'd1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

`default_nettype wire

// ===== hw/rtl/bascnd_if.sv =====
// ---------------------------------------------------------------------------
// bascnd_if
// Valid/ready channels carrying input samples and output levels.
// ---------------------------------------------------------------------------
`default_nettype none

interface bascnd_in_if;
    logic                         valid;
    logic                         ready;
    logic [bascnd_pkg::RAW_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface bascnd_out_if;
    logic                           valid;
    logic                           ready;
    logic [bascnd_pkg::LEVEL_W-1:0] level;
    logic                           clamped;

    modport source (output valid, output level, output clamped, input ready);
    modport sink   (input valid, input level, input clamped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bridge_adc_sample_conditioner_core.sv =====
// ---------------------------------------------------------------------------
// bridge_adc_sample_conditioner_core
// Phase/stability tracking and two-stage calibration of bridge ADC samples.
// ---------------------------------------------------------------------------
//  channel   dir  width  content
//  i_in      in   24     raw_sample
//  o_out     out  11+1   level, clamped
//  i_cfg_*   in   1/16   dir_gain, range_gain writes
//
//  A phase-0 beat is discarded and the block stays idle. A processed beat
//  makes one pass through the shared one-bit-per-cycle divider (37 steps),
//  or two (23 and 37 steps) with the first division, plus load and issue.
//  Reset is synchronous; gains return to 1000 and 10000.
//  The output register holds a result while o_out is stalled; the next beat
//  is taken meanwhile and waits only at its own result.
// ---------------------------------------------------------------------------
`default_nettype none

module bridge_adc_sample_conditioner_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    bascnd_in_if.sink                                 i_in,
    bascnd_out_if.source                              o_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bascnd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bascnd_pkg::GAIN_W-1:0]        i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LD1  = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_LD2  = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    logic [2:0]                       r_state, n_state;
    logic [bascnd_pkg::GAIN_W-1:0]    r_dir_gain, r_range_gain;
    logic [1:0]                       r_phase;
    logic [bascnd_pkg::CNT_W-1:0]     r_stable, r_unstable;
    logic [bascnd_pkg::CNT_W-1:0]     n_stable, n_unstable;
    logic [bascnd_pkg::HELD_W-1:0]    r_held;
    logic [bascnd_pkg::TLOW_W-1:0]    r_tlow;
    logic                             r_out_valid;
    logic [bascnd_pkg::LEVEL_W-1:0]   r_level;
    logic                             r_clamped;

    logic [bascnd_pkg::RAW_W-1:0]     t_full;
    logic [13:0]                      t_val;
    logic                             accept;
    logic                             put;
    logic [bascnd_pkg::GAIN_W-1:0]    dg, rg;
    logic [bascnd_pkg::HELD_W-1:0]    prod1;
    logic [bascnd_pkg::DIVD_W-1:0]    prod2;
    bascnd_pkg::t_div_req             div_req;
    logic [bascnd_pkg::DIVD_W-1:0]    div_dividend;
    logic [bascnd_pkg::GAIN_W-1:0]    div_divisor;
    logic                             div_busy;
    logic [bascnd_pkg::DIVD_W-1:0]    div_quot;
    logic                             over;

    assign t_full = (i_in.raw_sample ^ bascnd_pkg::ZERO_MID) >> bascnd_pkg::SAMPLE_SHIFT;
    assign t_val  = t_full[13:0];
    assign accept = i_in.valid && i_in.ready;
    assign put    = (r_state == S_PUT) && (!r_out_valid || o_out.ready);

    assign dg = (r_dir_gain == '0) ? bascnd_pkg::DIR_DEFAULT : r_dir_gain;
    assign rg = (r_range_gain == '0) ? bascnd_pkg::RANGE_DEFAULT : r_range_gain;

    assign prod1 = bascnd_pkg::HELD_W'(r_tlow) * bascnd_pkg::HELD_W'(bascnd_pkg::DIR_SCALE);
    assign prod2 = bascnd_pkg::DIVD_W'(r_held) * bascnd_pkg::DIVD_W'(bascnd_pkg::RANGE_SCALE);

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = bascnd_pkg::STEPS_RANGE;
        div_dividend  = prod2;
        div_divisor   = rg;
        if (r_state == S_LD1) begin
            div_req.start = 1'b1;
            div_req.steps = bascnd_pkg::STEPS_DIR;
            div_dividend  = {prod1, {(bascnd_pkg::DIVD_W - bascnd_pkg::HELD_W){1'b0}}};
            div_divisor   = dg;
        end else if (r_state == S_LD2) begin
            div_req.start = 1'b1;
        end
    end

    bascnd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign over = (div_quot > bascnd_pkg::CLAMP_LIMIT);

    always_comb begin
        n_stable   = r_stable;
        n_unstable = r_unstable;
        if (t_val[13]) begin
            n_unstable = '0;
            n_stable   = r_stable + 1'b1;
        end else begin
            n_unstable = r_unstable + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (r_phase != 2'd0)) begin
                    n_state = (t_val[13] && (n_stable > 8'd1)) ? S_LD1 : S_LD2;
                end
            end
            S_LD1:  n_state = S_DIV1;
            S_DIV1: if (!div_busy) n_state = S_LD2;
            S_LD2:  n_state = S_DIV2;
            S_DIV2: if (!div_busy) n_state = S_PUT;
            S_PUT:  if (put) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dir_gain   <= bascnd_pkg::DIR_DEFAULT;
            r_range_gain <= bascnd_pkg::RANGE_DEFAULT;
            r_phase      <= 2'd0;
            r_stable     <= '0;
            r_unstable   <= '0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bascnd_pkg::CFG_DIR_GAIN:   r_dir_gain   <= i_cfg_data;
                    bascnd_pkg::CFG_RANGE_GAIN: r_range_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (r_phase == 2'd0) begin
                    r_phase <= 2'd1;
                end else begin
                    if (r_phase == 2'd3) begin
                        r_phase    <= 2'd0;
                        r_stable   <= '0;
                        r_unstable <= '0;
                    end else begin
                        r_phase    <= r_phase + 2'd1;
                        r_stable   <= n_stable;
                        r_unstable <= n_unstable;
                    end
                    if (!t_val[13] && (n_unstable > 8'd1)) begin
                        r_held <= '0;
                    end
                end
            end
            if ((r_state == S_DIV1) && !div_busy) begin
                r_held <= div_quot[bascnd_pkg::HELD_W-1:0];
            end
            if (put) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tlow <= t_val[bascnd_pkg::TLOW_W-1:0];
        end
        if (put) begin
            r_level   <= over ? bascnd_pkg::CLAMP_VALUE : div_quot[bascnd_pkg::LEVEL_W-1:0];
            r_clamped <= over;
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.level   = r_level;
    assign o_out.clamped = r_clamped;

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= bascnd_pkg::HELD_MAX)
        else $error("held value out of range");

    a_put_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        put |=> r_out_valid)
        else $error("result not registered");

    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == 2'd0) |-> ((r_stable == '0) && (r_unstable == '0)))
        else $error("counters not cleared at window start");

    a_div_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LD1) || (r_state == S_LD2)) |=> div_busy)
        else $error("divider did not start");

endmodule

`default_nettype wire

// ===== hw/rtl/bascnd_div.sv =====
// ---------------------------------------------------------------------------
// bascnd_div
// Shared restoring divider, one quotient bit per cycle, MSB-aligned dividend.
// ---------------------------------------------------------------------------
`default_nettype none

module bascnd_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bascnd_pkg::t_div_req           i_req,
    input  wire logic [bascnd_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [bascnd_pkg::GAIN_W-1:0]  i_divisor,
    output logic                                o_busy,
    output logic [bascnd_pkg::DIVD_W-1:0]       o_quot
);

    logic [bascnd_pkg::DIVD_W-1:0] r_d, n_d;
    logic [bascnd_pkg::GAIN_W-1:0] r_rem, n_rem;
    logic [bascnd_pkg::GAIN_W-1:0] r_div;
    logic [bascnd_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic [bascnd_pkg::GAIN_W:0]   trial;
    logic [bascnd_pkg::GAIN_W:0]   diff;
    logic                          qbit;

    always_comb begin
        trial = {r_rem, r_d[bascnd_pkg::DIVD_W-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
        n_d   = r_d;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_req.start) begin
            n_d   = i_dividend;
            n_rem = '0;
            n_cnt = i_req.steps;
        end else if (r_cnt != '0) begin
            n_d   = {r_d[bascnd_pkg::DIVD_W-2:0], qbit};
            n_rem = qbit ? diff[bascnd_pkg::GAIN_W-1:0] : trial[bascnd_pkg::GAIN_W-1:0];
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_d   <= n_d;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_d;

endmodule

`default_nettype wire

// ===== test/bascnd_checker.sv =====
// ---------------------------------------------------------------------------
// bascnd_checker
// Watches the sample and level channels and the gain write port, predicts
// each level from its own copy of the window and hold state, and compares
// every output beat field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module bascnd_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    bascnd_in_if                                  in_ch,
    bascnd_out_if                                 out_ch,
    input  wire logic                             i_cfg_we,
    input  wire logic [bascnd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bascnd_pkg::GAIN_W-1:0]    i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    localparam logic [13:0] STABLE_FLOOR = 14'h2000;

    typedef struct packed {
        logic [bascnd_pkg::LEVEL_W-1:0] level;
        logic                           clamped;
    } t_level_beat;

    t_level_beat                   level_q[$];
    logic [1:0]                    win_phase;
    logic [bascnd_pkg::CNT_W-1:0]  n_stable;
    logic [bascnd_pkg::CNT_W-1:0]  n_unstable;
    logic [bascnd_pkg::HELD_W-1:0] hold_val;
    logic [bascnd_pkg::GAIN_W-1:0] div_dir;
    logic [bascnd_pkg::GAIN_W-1:0] div_range;

    function automatic bit calibrate_sample(input logic [bascnd_pkg::RAW_W-1:0] raw,
                                            output t_level_beat res);
        logic [13:0]                   t;
        logic [63:0]                   q;
        logic [bascnd_pkg::GAIN_W-1:0] dg;
        logic [bascnd_pkg::GAIN_W-1:0] rg;
        dg  = (div_dir == '0) ? bascnd_pkg::DIR_DEFAULT : div_dir;
        rg  = (div_range == '0) ? bascnd_pkg::RANGE_DEFAULT : div_range;
        res = '0;
        if (win_phase == 2'd0) begin
            win_phase = 2'd1;
            return 1'b0;
        end
        t = 14'((raw ^ bascnd_pkg::ZERO_MID) >> bascnd_pkg::SAMPLE_SHIFT);
        if (t >= STABLE_FLOOR) begin
            n_unstable = '0;
            n_stable   = n_stable + 1'b1;
            if (n_stable > 1)
                hold_val = bascnd_pkg::HELD_W'((64'(t - STABLE_FLOOR) *
                           64'(bascnd_pkg::DIR_SCALE)) / 64'(dg));
        end else begin
            n_unstable = n_unstable + 1'b1;
            if (n_unstable > 1)
                hold_val = '0;
        end
        q = (64'(hold_val) * 64'(bascnd_pkg::RANGE_SCALE)) / 64'(rg);
        if (q > 64'(bascnd_pkg::CLAMP_LIMIT)) begin
            res.level   = bascnd_pkg::CLAMP_VALUE;
            res.clamped = 1'b1;
        end else begin
            res.level = q[bascnd_pkg::LEVEL_W-1:0];
        end
        if (win_phase == 2'd3) begin
            win_phase  = 2'd0;
            n_stable   = '0;
            n_unstable = '0;
        end else begin
            win_phase = win_phase + 1'b1;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_level_beat got;
        t_level_beat want;
        t_level_beat pred;
        if (!i_rst_n) begin
            level_q.delete();
            win_phase  = '0;
            n_stable   = '0;
            n_unstable = '0;
            hold_val   = '0;
            div_dir    = bascnd_pkg::DIR_DEFAULT;
            div_range  = bascnd_pkg::RANGE_DEFAULT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bascnd_pkg::CFG_DIR_GAIN:   div_dir   = i_cfg_data;
                    bascnd_pkg::CFG_RANGE_GAIN: div_range = i_cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.level   = out_ch.level;
                got.clamped = out_ch.clamped;
                if (level_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t unexpected beat: expected none, got level %0d clamped %0b",
                             $time, got.level, got.clamped);
                end else begin
                    want = level_q.pop_front();
                    if (got.level !== want.level) begin
                        o_fail_count++;
                        $display("%0t level mismatch: expected %0d, got %0d",
                                 $time, want.level, got.level);
                    end
                    if (got.clamped !== want.clamped) begin
                        o_fail_count++;
                        $display("%0t clamped mismatch: expected %0b, got %0b",
                                 $time, want.clamped, got.clamped);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (calibrate_sample(in_ch.raw_sample, pred))
                    level_q.push_back(pred);
            end
        end
        o_pending = level_q.size();
    end

endmodule

// ===== test/bridge_adc_sample_conditioner_core_tb.sv =====
// ---------------------------------------------------------------------------
// bridge_adc_sample_conditioner_core_tb
// Drives directed and random ADC samples through the conditioner under
// several gain settings and idle patterns; a checker beside the block
// predicts and compares every level beat.
// ---------------------------------------------------------------------------
module bridge_adc_sample_conditioner_core_tb;

    localparam int N_PLANS      = 7;
    localparam int ITEMS_PER    = 100;
    localparam int SETTLE       = 100;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [bascnd_pkg::RAW_W-1:0] DIRECTED [24] = '{
        24'h123456, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
        24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h055400,
        24'hABCDEF, 24'h156000, 24'h156000, 24'h156400,
        24'h5A5A5A, 24'h100000, 24'hC00000, 24'h100000,
        24'h000001, 24'hF00000, 24'h200000, 24'h900000
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [bascnd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [bascnd_pkg::GAIN_W-1:0]    cfg_data;
    int                               fail_count;
    int                               pending;
    int                               cycles;
    int                               send_idle_pct;
    int                               recv_idle_pct;
    logic [bascnd_pkg::GAIN_W-1:0]    dg_plan [N_PLANS];
    logic [bascnd_pkg::GAIN_W-1:0]    rg_plan [N_PLANS];

    bascnd_in_if  in_ch ();
    bascnd_out_if out_ch ();

    bridge_adc_sample_conditioner_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bascnd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input logic [bascnd_pkg::RAW_W-1:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid      <= 1'b0;
            in_ch.raw_sample <= bascnd_pkg::RAW_W'($urandom);
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.raw_sample <= raw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // sender holds off until every predicted level has come back
    task automatic drain;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gains(input logic [bascnd_pkg::GAIN_W-1:0] dg,
                               input logic [bascnd_pkg::GAIN_W-1:0] rg);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= bascnd_pkg::CFG_DIR_GAIN;
        cfg_data <= dg;
        @(negedge clk);
        cfg_idx  <= bascnd_pkg::CFG_RANGE_GAIN;
        cfg_data <= rg;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [bascnd_pkg::RAW_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return bascnd_pkg::RAW_W'($urandom_range(0, 24'h7FFFFF));
        else if (roll < 70)
            return bascnd_pkg::RAW_W'($urandom_range(0, 24'h03FFFF));
        return bascnd_pkg::RAW_W'($urandom);
    endfunction

    initial begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.raw_sample <= '0;
        cfg_we           <= 1'b0;
        cfg_idx          <= bascnd_pkg::CFG_DIR_GAIN;
        cfg_data         <= '0;
        send_idle_pct    = 12;
        recv_idle_pct    = 55;
        dg_plan = '{16'd1, 16'd65535, 16'd0, 16'd8000, 16'd6000, 16'd0, 16'd65535};
        rg_plan = '{16'd65535, 16'd1, 16'd0, 16'd10000, 16'd10000, 16'd0, 16'd65535};
        dg_plan[5] = bascnd_pkg::GAIN_W'($urandom_range(1, 65535));
        rg_plan[5] = bascnd_pkg::GAIN_W'($urandom_range(1, 65535));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_sample(DIRECTED[i]);
        drain();

        for (int p = 0; p < N_PLANS; p++) begin
            if (p < 3) begin
                send_idle_pct = 12;
                recv_idle_pct = 55;
            end else if (p < 5) begin
                send_idle_pct = 55;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_gains(dg_plan[p], rg_plan[p]);
            for (int n = 0; n < ITEMS_PER; n++)
                send_sample(pick_sample());
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bascnd_pkg.sv
hw/rtl/bascnd_if.sv
hw/rtl/bascnd_div.sv
hw/rtl/bridge_adc_sample_conditioner_core.sv
test/bascnd_checker.sv
test/bridge_adc_sample_conditioner_core_tb.sv
